[design/bspl_pkg.sv]
// bspl_pkg: shared widths, codes and structs for the BSP point locator.
// No dependencies; used by the interfaces and every design module.
package bspl_pkg;

    localparam int NODES_DEF = 4096;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int CHILD_W   = 16;
    localparam int LEAF_W    = 15;
    localparam int COUNT_W   = 13;
    localparam int SLOT_W    = 12;
    localparam int PROD_W    = 2 * COORD_W - FRAC_BITS;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOCATE = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic [CHILD_W-1:0]        child_front;
        logic [CHILD_W-1:0]        child_back;
    } node_entry_t;

    typedef struct packed {
        logic done;
        logic side;
    } side_res_t;

endpackage

[design/bspl_if.sv]
// bspl_if: valid/ready channel interfaces for request, result and config.
// Depends on bspl_pkg for field widths.
interface bspl_req_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [bspl_pkg::SLOT_W-1:0]         node_index;
    logic signed [bspl_pkg::COORD_W-1:0] coord_x;
    logic signed [bspl_pkg::COORD_W-1:0] coord_y;
    logic signed [bspl_pkg::COORD_W-1:0] delta_x;
    logic signed [bspl_pkg::COORD_W-1:0] delta_y;
    logic [bspl_pkg::CHILD_W-1:0]        child_front;
    logic [bspl_pkg::CHILD_W-1:0]        child_back;

    modport source (output valid, action, node_index, coord_x, coord_y, delta_x, delta_y,
                    child_front, child_back, input ready);
    modport sink (input valid, action, node_index, coord_x, coord_y, delta_x, delta_y,
                  child_front, child_back, output ready);
endinterface

interface bspl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bspl_pkg::LEAF_W-1:0]   leaf_index;
    logic [bspl_pkg::COUNT_W-1:0]  steps_taken;
    logic                          walk_overrun;

    modport source (output valid, leaf_index, steps_taken, walk_overrun, input ready);
    modport sink (input valid, leaf_index, steps_taken, walk_overrun, output ready);
endinterface

interface bspl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bspl_pkg::COUNT_W-1:0]  node_count;

    modport source (output valid, node_count, input ready);
    modport sink (input valid, node_count, output ready);
endinterface

[design/bsp_point_locate.sv]
// Write transfer: taken only while idle, stored at the edge that takes it.
// Locate: each node is fetched, then side-tested by a quick test or both multiplies,
// and a child index beyond the table is folded into it before the next fetch; one item at a time.
// The node walk is bound by the memory read and the side-test multiplier.
// Reset clears node_count and control; the node table is not cleared.
module bsp_point_locate #(
    parameter int NODES = bspl_pkg::NODES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bspl_req_if.sink    req,
    bspl_rsp_if.source  rsp,
    bspl_cfg_if.sink    cfg
);

    localparam int AW     = $clog2(NODES);
    localparam int STEP_W = $clog2(NODES + 1);
    localparam int CW     = bspl_pkg::CHILD_W;
    localparam int LW     = bspl_pkg::LEAF_W;
    // reciprocal of NODES, exact for every child index below 2^15
    localparam int RECIP_SH = 30;
    localparam int RECIP_W  = 31;
    localparam int QP_W     = LW + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << RECIP_SH) + NODES - 1) / NODES);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FETCH  = 7'b0000010,
        ST_SIDE   = 7'b0000100,
        ST_WAIT   = 7'b0001000,
        ST_REDUCE = 7'b0010000,
        ST_FOLD   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } st_t;

    st_t state_reg, state_next;

    logic [bspl_pkg::COUNT_W-1:0] node_count_reg;
    logic [AW-1:0]                node_reg, node_next;
    logic [STEP_W-1:0]            steps_reg, steps_next;
    logic [LW-1:0]                leaf_reg, leaf_next;
    logic                         over_reg, over_next;
    logic [LW-1:0]                rem_reg, rem_next;
    logic [LW-1:0]                quo_reg;
    logic signed [bspl_pkg::COORD_W-1:0] pt_x_reg, pt_y_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [LW-1:0]                out_leaf_reg;
    logic [bspl_pkg::COUNT_W-1:0] out_steps_reg;
    logic                         out_over_reg;

    logic                  req_xfer;
    logic                  mem_wr_en;
    bspl_pkg::node_entry_t mem_wr_data;
    bspl_pkg::node_entry_t mem_rd_data;
    bspl_pkg::side_res_t   side_res;

    logic [31:0]     count_clip;
    logic [CW-1:0]   child;
    logic [QP_W-1:0] quo_prod;
    logic [31:0]     fold_mul;
    logic [LW-1:0]   fold_idx;

    assign req_xfer  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign mem_wr_en = req_xfer && (req.action == bspl_pkg::ACT_WRITE)
                       && (32'(req.node_index) < 32'(NODES));

    assign mem_wr_data.origin_x    = req.coord_x;
    assign mem_wr_data.origin_y    = req.coord_y;
    assign mem_wr_data.dir_x       = req.delta_x;
    assign mem_wr_data.dir_y       = req.delta_y;
    assign mem_wr_data.child_front = req.child_front;
    assign mem_wr_data.child_back  = req.child_back;

    bspl_node_mem #(
        .NODES (NODES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (AW'(req.node_index)),
        .wr_data (mem_wr_data),
        .rd_en   (state_reg == ST_FETCH),
        .rd_addr (node_reg),
        .rd_data (mem_rd_data)
    );

    bspl_side_test u_side (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == ST_SIDE),
        .point_x (pt_x_reg),
        .point_y (pt_y_reg),
        .entry   (mem_rd_data),
        .res     (side_res)
    );

    always_comb
    begin
        count_clip = (32'(node_count_reg) > 32'(NODES)) ? 32'(NODES) : 32'(node_count_reg);
        child      = side_res.side ? mem_rd_data.child_back : mem_rd_data.child_front;
        quo_prod   = QP_W'(rem_reg) * QP_W'(RECIP);
        fold_mul   = 32'(quo_reg) * 32'(NODES);
        fold_idx   = rem_reg - LW'(fold_mul);
    end

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        steps_next     = steps_reg;
        leaf_next      = leaf_reg;
        over_next      = over_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && req.action == bspl_pkg::ACT_LOCATE)
                begin
                    steps_next = '0;
                    leaf_next  = '0;
                    over_next  = 1'b0;
                    if (count_clip == 32'd0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        node_next  = AW'(count_clip - 32'd1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                steps_next = steps_reg + STEP_W'(1);
                state_next = ST_SIDE;
            end
            ST_SIDE: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (side_res.done)
                begin
                    priority if (child[CW-1])
                    begin
                        leaf_next  = child[LW-1:0];
                        state_next = ST_DONE;
                    end
                    else if (32'(steps_reg) >= 32'(NODES))
                    begin
                        over_next  = 1'b1;
                        leaf_next  = '0;
                        state_next = ST_DONE;
                    end
                    else if (32'(child) >= 32'(NODES))
                    begin
                        rem_next   = child[LW-1:0];
                        state_next = ST_REDUCE;
                    end
                    else
                    begin
                        node_next  = AW'(child);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_REDUCE: state_next = ST_FOLD;
            ST_FOLD:
            begin
                node_next  = AW'(fold_idx);
                state_next = ST_FETCH;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            steps_reg      <= '0;
            over_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
            over_reg      <= over_next;
            if (cfg.valid && cfg.ready)
            begin
                node_count_reg <= cfg.node_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        leaf_reg <= leaf_next;
        rem_reg  <= rem_next;
        if (state_reg == ST_REDUCE)
        begin
            quo_reg <= quo_prod[RECIP_SH +: LW];
        end
        if (req_xfer)
        begin
            pt_x_reg <= req.coord_x;
            pt_y_reg <= req.coord_y;
        end
        if (state_reg == ST_DONE && (!out_valid_reg || rsp.ready))
        begin
            out_leaf_reg  <= leaf_reg;
            out_steps_reg <= bspl_pkg::COUNT_W'(steps_reg);
            out_over_reg  <= over_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.leaf_index   = out_leaf_reg;
    assign rsp.steps_taken  = out_steps_reg;
    assign rsp.walk_overrun = out_over_reg;

`ifndef SYNTHESIS
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(steps_reg) <= 32'(NODES))
        else $error("walk step count above table size");

    a_fetch_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> (32'(node_reg) < 32'(NODES)))
        else $error("node fetch outside table");

    a_side_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        side_res.done |-> (state_reg == ST_WAIT))
        else $error("side result arrived outside wait state");

    a_overrun_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_over_reg) |-> (out_leaf_reg == '0))
        else $error("overrun result carries a leaf");
`endif

endmodule

[design/bspl_node_mem.sv]
// bspl_node_mem: node table, one write port and one registered read port.
// Depends on bspl_pkg for the node entry struct.
module bspl_node_mem #(
    parameter int NODES = bspl_pkg::NODES_DEF,
    parameter int AW    = $clog2(NODES)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  bspl_pkg::node_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output bspl_pkg::node_entry_t rd_data
);

    bspl_pkg::node_entry_t mem [NODES];
    bspl_pkg::node_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/bspl_side_test.sv]
// bspl_side_test: which side of a partition line a point lies on.
// Quick tests decide without multiplying; else two shared-free multiplies and a compare.
// Depends on bspl_pkg.
module bspl_side_test (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [bspl_pkg::COORD_W-1:0] point_x,
    input  logic signed [bspl_pkg::COORD_W-1:0] point_y,
    input  bspl_pkg::node_entry_t               entry,
    output bspl_pkg::side_res_t                 res
);

    localparam int CW = bspl_pkg::COORD_W;
    localparam int FB = bspl_pkg::FRAC_BITS;
    localparam int PW = bspl_pkg::PROD_W;
    localparam int IW = CW - FB;

    typedef enum logic [3:0] {
        SD_IDLE = 4'b0001,
        SD_MULA = 4'b0010,
        SD_MULB = 4'b0100,
        SD_CMP  = 4'b1000
    } sd_state_t;

    sd_state_t state_reg, state_next;
    logic      done_reg, done_next;
    logic      side_reg, side_next;

    logic signed [CW-1:0] rx, ry;
    logic                 quick_hit;
    logic                 quick_side;

    logic signed [CW-1:0] rx_reg, ry_reg;
    logic signed [IW-1:0] dxi_reg, dyi_reg;
    logic signed [PW-1:0] prod_a_reg, prod_b_reg;

    always_comb
    begin
        rx = point_x - entry.origin_x;
        ry = point_y - entry.origin_y;
        quick_hit  = 1'b1;
        quick_side = 1'b0;
        if (entry.dir_x == '0)
        begin
            quick_side = (point_x <= entry.origin_x) ? (entry.dir_y > 0) : (entry.dir_y < 0);
        end
        else if (entry.dir_y == '0)
        begin
            quick_side = (point_y <= entry.origin_y) ? (entry.dir_x < 0) : (entry.dir_x > 0);
        end
        else if (entry.dir_y[CW-1] ^ entry.dir_x[CW-1] ^ rx[CW-1] ^ ry[CW-1])
        begin
            quick_side = entry.dir_y[CW-1] ^ rx[CW-1];
        end
        else
        begin
            quick_hit = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        side_next  = side_reg;
        unique case (state_reg)
            SD_IDLE:
            begin
                if (start)
                begin
                    if (quick_hit)
                    begin
                        done_next = 1'b1;
                        side_next = quick_side;
                    end
                    else
                    begin
                        state_next = SD_MULA;
                    end
                end
            end
            SD_MULA: state_next = SD_MULB;
            SD_MULB: state_next = SD_CMP;
            SD_CMP:
            begin
                done_next  = 1'b1;
                side_next  = $signed(prod_a_reg[PW-1:FB]) >= $signed(prod_b_reg[PW-1:FB]);
                state_next = SD_IDLE;
            end
            default: state_next = SD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SD_IDLE;
            done_reg  <= 1'b0;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            side_reg  <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SD_IDLE && start)
        begin
            rx_reg  <= rx;
            ry_reg  <= ry;
            dxi_reg <= entry.dir_x[CW-1:FB];
            dyi_reg <= entry.dir_y[CW-1:FB];
        end
        if (state_reg == SD_MULA)
        begin
            prod_a_reg <= ry_reg * dxi_reg;
        end
        if (state_reg == SD_MULB)
        begin
            prod_b_reg <= dyi_reg * rx_reg;
        end
    end

    assign res.done = done_reg;
    assign res.side = side_reg;

endmodule

[dv/tb_bsp_point_locate.sv]
// tb_bsp_point_locate: self-checking testbench for the BSP point locator.
// Needs bspl_pkg, the bspl_*_if interfaces and bsp_point_locate; drives
// node writes and locates, predicts each walk and checks every result transfer.
module tb_bsp_point_locate;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES_DEF = bspl_pkg::NODES_DEF;
    localparam int FRAC_BITS = bspl_pkg::FRAC_BITS;
    localparam int COORD_W   = bspl_pkg::COORD_W;
    localparam int CHILD_W   = bspl_pkg::CHILD_W;
    localparam int LEAF_W    = bspl_pkg::LEAF_W;
    localparam int COUNT_W   = bspl_pkg::COUNT_W;
    localparam int SLOT_W    = bspl_pkg::SLOT_W;

    typedef struct {
        logic                      action;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
        logic [CHILD_W-1:0]        front;
        logic [CHILD_W-1:0]        back;
        bit                        hold;
    } bsp_req_t;

    typedef struct packed {
        logic [LEAF_W-1:0]  leaf;
        logic [COUNT_W-1:0] steps;
        logic               overrun;
    } locate_res_t;

    logic clk = 1'b0;
    logic rst_n;

    bspl_req_if req_ch ();
    bspl_rsp_if rsp_ch ();
    bspl_cfg_if cfg_ch ();

    bsp_point_locate #(.NODES(NODES_DEF)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    bspl_pkg::node_entry_t node_tab [NODES_DEF];
    logic [COUNT_W-1:0]    model_count;
    locate_res_t           leaf_q [$];
    bsp_req_t              pend_q [$];
    bsp_req_t              drv_item;
    bit                    drv_busy;
    int                    drv_gap;
    int                    mon_stall;
    int                    errors = 0;
    bit                    no_idle = 1'b0;

    bit gen_written [NODES_DEF];
    int gen_slots [$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic point_side(bspl_pkg::node_entry_t n,
                                        logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y);
        logic signed [COORD_W-1:0] ox, oy, dx, dy, rx, ry;
        logic signed [63:0]        rx64, ry64, dxi, dyi, lhs, rhs;
        ox = n.origin_x;
        oy = n.origin_y;
        dx = n.dir_x;
        dy = n.dir_y;
        if (dx == 0)
            return (x <= ox) ? (dy > 0) : (dy < 0);
        if (dy == 0)
            return (y <= oy) ? (dx < 0) : (dx > 0);
        rx = x - ox;
        ry = y - oy;
        if (dy[COORD_W-1] ^ dx[COORD_W-1] ^ rx[COORD_W-1] ^ ry[COORD_W-1])
            return dy[COORD_W-1] ^ rx[COORD_W-1];
        rx64 = rx;
        ry64 = ry;
        dxi  = dx >>> FRAC_BITS;
        dyi  = dy >>> FRAC_BITS;
        lhs  = (ry64 * dxi) >>> FRAC_BITS;
        rhs  = (dyi * rx64) >>> FRAC_BITS;
        return lhs >= rhs;
    endfunction

    function automatic locate_res_t walk_tree(logic signed [COORD_W-1:0] x,
                                              logic signed [COORD_W-1:0] y);
        locate_res_t        r;
        int                 count, steps, idx;
        logic [CHILD_W-1:0] cur;
        r = '0;
        count = (model_count > NODES_DEF) ? NODES_DEF : int'(model_count);
        if (count == 0)
            return r;
        cur = CHILD_W'(count - 1);
        steps = 0;
        forever
        begin
            if (cur[CHILD_W-1])
            begin
                r.leaf = cur[LEAF_W-1:0];
                break;
            end
            if (steps >= NODES_DEF)
            begin
                r.overrun = 1'b1;
                break;
            end
            idx = int'(cur) % NODES_DEF;
            steps++;
            cur = point_side(node_tab[idx], x, y) ? node_tab[idx].child_back
                                                  : node_tab[idx].child_front;
        end
        r.steps = COUNT_W'(steps);
        return r;
    endfunction

    function automatic int next_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return int'($urandom_range(0, 32'h1FFFFF)) - 32'h100000;
        if (r < 8)
            return $urandom;
        if (r == 8)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh80000000;
                1: return 32'sh7FFFFFFF;
                2: return 32'sh0;
                default: return -32'sh1;
            endcase
        end
        return (int'($urandom_range(0, 64)) - 32) <<< FRAC_BITS;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return 32'sh0;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh80000000;
                    1: return 32'sh7FFFFFFF;
                    2: return 32'sh10000;
                    default: return -32'sh10000;
                endcase
            end
            2: return int'($urandom_range(0, 32'h1FFFFF)) - 32'h100000;
            default: return $urandom;
        endcase
    endfunction

    // non-leaf children only point at written slots below the node: no cycles
    function automatic logic [CHILD_W-1:0] rand_child(int slot);
        int c, t;
        t = -1;
        if ($urandom_range(0, 2) != 0 && gen_slots.size() > 0)
            for (int k = 0; k < 8 && t < 0; k++)
            begin
                c = gen_slots[$urandom_range(0, gen_slots.size() - 1)];
                if (c < slot)
                    t = c;
            end
        if (t < 0)
            return {1'b1, LEAF_W'($urandom)};
        return {1'b0, 3'($urandom), SLOT_W'(t)};
    endfunction

    function automatic void push_write(int slot, logic signed [COORD_W-1:0] ox,
                                       logic signed [COORD_W-1:0] oy,
                                       logic signed [COORD_W-1:0] dx,
                                       logic signed [COORD_W-1:0] dy,
                                       logic [CHILD_W-1:0] f, logic [CHILD_W-1:0] b);
        bsp_req_t it;
        it = '{action: bspl_pkg::ACT_WRITE, slot: SLOT_W'(slot), cx: ox, cy: oy, dx: dx,
               dy: dy, front: f, back: b, hold: 1'b0};
        pend_q.push_back(it);
        if (!gen_written[slot])
        begin
            gen_written[slot] = 1'b1;
            gen_slots.push_back(slot);
        end
    endfunction

    function automatic void push_locate(logic signed [COORD_W-1:0] x,
                                        logic signed [COORD_W-1:0] y);
        bsp_req_t it;
        it = '{action: bspl_pkg::ACT_LOCATE, slot: SLOT_W'($urandom), cx: x, cy: y,
               dx: $urandom, dy: $urandom, front: CHILD_W'($urandom),
               back: CHILD_W'($urandom), hold: 1'b0};
        pend_q.push_back(it);
    endfunction

    task automatic wait_idle();
        while (pend_q.size() != 0 || drv_busy || leaf_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic cfg_write(int value);
        @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.node_count <= COUNT_W'(value);
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        model_count = COUNT_W'(value);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.action      <= bspl_pkg::ACT_WRITE;
            req_ch.node_index  <= '0;
            req_ch.coord_x     <= '0;
            req_ch.coord_y     <= '0;
            req_ch.delta_x     <= '0;
            req_ch.delta_y     <= '0;
            req_ch.child_front <= '0;
            req_ch.child_back  <= '0;
            drv_busy = 1'b0;
            drv_gap  = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (drv_item.action == bspl_pkg::ACT_WRITE)
                    node_tab[drv_item.slot] = '{origin_x: drv_item.cx,
                                                origin_y: drv_item.cy,
                                                dir_x: drv_item.dx,
                                                dir_y: drv_item.dy,
                                                child_front: drv_item.front,
                                                child_back: drv_item.back};
                else
                    leaf_q.push_back(walk_tree(drv_item.cx, drv_item.cy));
                drv_busy = 1'b0;
                drv_gap  = next_gap();
            end
            if (!drv_busy)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (pend_q.size() > 0 && (!pend_q[0].hold || leaf_q.size() == 0))
                begin
                    drv_item = pend_q.pop_front();
                    drv_busy = 1'b1;
                end
            end
            req_ch.valid <= drv_busy;
            if (drv_busy)
            begin
                req_ch.action      <= drv_item.action;
                req_ch.node_index  <= drv_item.slot;
                req_ch.coord_x     <= drv_item.cx;
                req_ch.coord_y     <= drv_item.cy;
                req_ch.delta_x     <= drv_item.dx;
                req_ch.delta_y     <= drv_item.dy;
                req_ch.child_front <= drv_item.front;
                req_ch.child_back  <= drv_item.back;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        locate_res_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            mon_stall = 0;
        end
        else
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready)
            begin
                if (leaf_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: leaf %0d steps %0d overrun %0b",
                                 rsp_ch.leaf_index, rsp_ch.steps_taken, rsp_ch.walk_overrun);
                end
                else
                begin
                    want = leaf_q.pop_front();
                    if (rsp_ch.leaf_index !== want.leaf || rsp_ch.steps_taken !== want.steps
                        || rsp_ch.walk_overrun !== want.overrun)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch leaf/steps/overrun: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     want.leaf, want.steps, want.overrun,
                                     rsp_ch.leaf_index, rsp_ch.steps_taken,
                                     rsp_ch.walk_overrun);
                    end
                end
            end
            if (mon_stall > 0)
            begin
                mon_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                mon_stall = next_gap();
            end
        end
    end

    initial
    begin
        int count;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.node_count <= '0;
        model_count = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty tree
        push_locate(32'sh80000000, 32'sh7FFFFFFF);
        push_locate(32'sh0, 32'sh0);
        // vertical, horizontal and general lines; folded child indexes
        push_write(0, 32'sh0, 32'sh0, 32'sh0, 32'sh10000, 16'h8001, 16'h8002);
        push_write(1, 32'sh10000, -32'sh20000, -32'sh10000, 32'sh0, 16'h8003, 16'h7000);
        push_write(2, 32'sh100000, -32'sh100000, 32'sh10000, 32'sh20000, 16'h1001, 16'hFFFF);
        push_write(NODES_DEF - 1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                   16'h2002, 16'h8000);
        wait_idle();
        cfg_write(NODES_DEF);
        push_locate(32'sh0, 32'sh0);
        push_locate(32'sh80000000, 32'sh80000000);
        push_locate(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        push_locate(-32'sh1, 32'sh1);
        push_locate(32'sh100000, -32'sh100000);
        push_locate(32'sh200000, 32'sh7FFFFFFF);
        wait_idle();
        cfg_write(3);
        for (int i = 0; i < 3; i++)
            push_locate(rand_coord(), rand_coord());
        wait_idle();
        cfg_write(1);
        push_locate(-32'sh10000, 32'sh5);
        push_locate(32'sh10000, 32'sh5);
        wait_idle();
        // self-loops: the walk runs out of steps, plain and with folded index
        push_write(10, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 16'd10, 16'd10);
        wait_idle();
        cfg_write(11);
        push_locate(32'sh1, 32'sh1);
        wait_idle();
        push_write(11, 32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 16'h700B, 16'h700B);
        wait_idle();
        cfg_write(12);
        push_locate(rand_coord(), rand_coord());
        wait_idle();
        push_write(10, rand_coord(), rand_coord(), rand_dir(), rand_dir(), 16'h8004, 16'h8005);
        push_write(11, rand_coord(), rand_coord(), rand_dir(), rand_dir(), 16'h800A, 16'h0002);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            no_idle = (ph == 3);
            if (ph == 0)
                count = NODES_DEF;
            else if (ph == 5)
                count = 0;
            else
                count = gen_slots[$urandom_range(0, gen_slots.size() - 1)] + 1;
            cfg_write(count);
            for (int i = 0; i < 50; i++)
            begin
                if ($urandom_range(0, 9) < 4)
                begin
                    int slot;
                    slot = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, NODES_DEF - 1);
                    push_write(slot, rand_coord(), rand_coord(), rand_dir(), rand_dir(),
                               rand_child(slot), rand_child(slot));
                end
                else
                    push_locate(rand_coord(), rand_coord());
                if (i == 25 || $urandom_range(0, 39) == 0)
                    pend_q[pend_q.size() - 1].hold = 1'b1;
            end
            wait_idle();
        end

        if (leaf_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[bsp_point_locate.f]
design/bspl_pkg.sv
design/bspl_if.sv
design/bspl_node_mem.sv
design/bspl_side_test.sv
design/bsp_point_locate.sv
dv/tb_bsp_point_locate.sv
